// ===== hw/rtl/xed_pkg.sv =====
`timescale 1ns / 1ps

package xed_pkg;

	localparam int CHAR_W = 21;
	localparam int NAME_N = 6;
	localparam int ACC_W  = 25;

	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [2:0]        name_idx_t;
	typedef logic [7:0]        byte_t;

	localparam char_t CH_AMP  = 21'h000026;
	localparam char_t CH_SEMI = 21'h00003B;
	localparam char_t CH_HASH = 21'h000023;
	localparam char_t CH_X    = 21'h000078;
	localparam char_t CH_0    = 21'h000030;
	localparam char_t CH_9    = 21'h000039;
	localparam char_t CH_LA   = 21'h000061;
	localparam char_t CH_LF   = 21'h000066;
	localparam char_t CH_UA   = 21'h000041;
	localparam char_t CH_UF   = 21'h000046;
	localparam char_t CP_MAX  = 21'h10FFFF;

	typedef enum logic {
		ST_RUN,
		ST_FLUSH
	} ctrl_state_t;

	typedef struct packed {
		logic accept;
		logic flush;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
		logic go_flush;
		logic flush_done;
	} dp_status_t;

	function automatic logic [2:0] name_len(input name_idx_t k);
		logic [2:0] n;
		unique case (k)
			3'd0: n = 3'd5;
			3'd1: n = 3'd4;
			3'd2: n = 3'd4;
			3'd3: n = 3'd6;
			3'd4: n = 3'd6;
			3'd5: n = 3'd6;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

	function automatic char_t name_code(input name_idx_t k);
		char_t c;
		unique case (k)
			3'd0: c = 21'h000026;
			3'd1: c = 21'h00003C;
			3'd2: c = 21'h00003E;
			3'd3: c = 21'h000027;
			3'd4: c = 21'h000022;
			3'd5: c = 21'h00000A;
			default: c = '0;
		endcase
		return c;
	endfunction

	function automatic byte_t name_char(input name_idx_t k, input logic [2:0] i);
		logic [0:5][7:0] s;
		unique case (k)
			3'd0: s = {"&amp;", 8'h00};
			3'd1: s = {"&lt;", 16'h0000};
			3'd2: s = {"&gt;", 16'h0000};
			3'd3: s = "&apos;";
			3'd4: s = "&quot;";
			3'd5: s = "&#x0A;";
			default: s = '0;
		endcase
		if (i > 3'd5) begin
			return 8'h00;
		end
		return s[i];
	endfunction

endpackage

// ===== hw/rtl/xed_ifs.sv =====
`timescale 1ns / 1ps

interface xed_in_if;
	logic                  valid;
	logic                  ready;
	logic [xed_pkg::CHAR_W-1:0] char_in;
	logic                  last_in_text;

	modport source(output valid, output char_in, output last_in_text, input ready);
	modport sink(input valid, input char_in, input last_in_text, output ready);
endinterface

interface xed_out_if;
	logic                  valid;
	logic                  ready;
	logic [xed_pkg::CHAR_W-1:0] char_out;
	logic                  run_last;
	logic                  text_end;

	modport source(output valid, output char_out, output run_last, output text_end,
		input ready);
	modport sink(input valid, input char_out, input run_last, input text_end,
		output ready);
endinterface

// ===== hw/rtl/xed_ctrl.sv =====
`timescale 1ns / 1ps

module xed_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  xed_pkg::dp_status_t st,
	output xed_pkg::dp_cmd_t    cmd
);

	xed_pkg::ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= xed_pkg::ST_RUN;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			xed_pkg::ST_RUN: begin
				in_ready   = st.out_free;
				cmd.accept = in_valid && st.out_free;
				if (cmd.accept && st.go_flush) begin
					state_d = xed_pkg::ST_FLUSH;
				end
			end
			xed_pkg::ST_FLUSH: begin
				cmd.flush = 1'b1;
				if (st.flush_done) begin
					state_d = xed_pkg::ST_RUN;
				end
			end
		endcase
	end

endmodule

// ===== hw/rtl/xed_dpath.sv =====
`timescale 1ns / 1ps

module xed_dpath #(
	parameter int MAX_SEQ = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  xed_pkg::dp_cmd_t    cmd,
	output xed_pkg::dp_status_t st,
	input  xed_pkg::char_t      char_in,
	input  logic                last_in_text,
	output xed_pkg::char_t      char_out,
	output logic                run_last,
	output logic                text_end,
	output logic                out_valid,
	input  logic                out_ready
);

	localparam int AW = $clog2(MAX_SEQ);
	localparam int CW = xed_pkg::CHAR_W;
	localparam int NN = xed_pkg::NAME_N;
	localparam int XW = xed_pkg::ACC_W;
	localparam logic [AW-1:0] POS_FULL = AW'(MAX_SEQ - 1);

	xed_pkg::char_t seq_mem [MAX_SEQ];

	// sequence tracking
	logic          building_q;
	logic [AW-1:0] pos_q;
	logic [NN-1:0] name_ok_q;
	logic          hash_ok_q, hex_q, bad_q, ndig_q, ovf_q;
	xed_pkg::char_t acc_q;

	// flush read pipeline
	logic [AW-1:0] iss_q, end_q;
	logic          iss_done_q, flush_te_q;
	xed_pkg::char_t rd_data_s1;
	logic          rd_last_s1, data_vld_s1;

	// result register
	logic          out_valid_q, run_last_q, text_end_q;
	xed_pkg::char_t char_out_q;

	logic          is_amp, is_semi, is_hash, dec_d, alpha_d, dig_ok;
	logic [3:0]    dval;
	logic [XW-1:0] acc_w, mul, acc_next;
	logic [NN-1:0] name_step, name_hit;
	logic          any_name, num_ok, hit, go_flush, emit_now, load, rd_en, out_free;
	xed_pkg::char_t name_val, hit_val;

	assign is_amp  = char_in == xed_pkg::CH_AMP;
	assign is_semi = char_in == xed_pkg::CH_SEMI;
	assign is_hash = char_in == xed_pkg::CH_HASH;
	assign dec_d   = char_in >= xed_pkg::CH_0 && char_in <= xed_pkg::CH_9;
	assign alpha_d = (char_in >= xed_pkg::CH_LA && char_in <= xed_pkg::CH_LF) ||
		(char_in >= xed_pkg::CH_UA && char_in <= xed_pkg::CH_UF);
	assign dig_ok  = dec_d || (hex_q && alpha_d);
	assign dval    = dec_d ? char_in[3:0] : 4'(char_in[3:0] + 4'd9);

	assign acc_w    = XW'(acc_q);
	assign mul      = hex_q ? (acc_w << 4) : ((acc_w << 3) + (acc_w << 1));
	assign acc_next = mul + XW'(dval);

	always_comb begin
		name_val = '0;
		for (int k = 0; k < NN; k++) begin
			name_step[k] = name_ok_q[k] &&
				(pos_q < AW'(xed_pkg::name_len(xed_pkg::name_idx_t'(k)))) &&
				(char_in == CW'(xed_pkg::name_char(xed_pkg::name_idx_t'(k), pos_q[2:0])));
			name_hit[k] = name_ok_q[k] &&
				(pos_q == AW'(xed_pkg::name_len(xed_pkg::name_idx_t'(k)) - 3'd1));
		end
		for (int k = NN - 1; k >= 0; k--) begin
			if (name_hit[k]) begin
				name_val = xed_pkg::name_code(xed_pkg::name_idx_t'(k));
			end
		end
	end

	assign any_name = |name_hit;
	assign num_ok   = (pos_q >= AW'(2)) && hash_ok_q && !bad_q && ndig_q && !ovf_q;
	assign hit      = is_semi && (any_name || num_ok);
	assign hit_val  = any_name ? name_val : acc_q;
	assign go_flush = building_q &&
		(is_semi ? !hit : (pos_q == POS_FULL || last_in_text));
	assign emit_now = cmd.accept && (building_q ? hit : (!is_amp || last_in_text));

	assign out_free = !out_valid_q || out_ready;
	assign load     = cmd.flush && data_vld_s1 && out_free;
	assign rd_en    = cmd.flush && !iss_done_q && (!data_vld_s1 || load);

	assign st.out_free   = out_free;
	assign st.go_flush   = go_flush;
	assign st.flush_done = load && rd_last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			building_q <= 1'b0;
			pos_q      <= '0;
		end else if (cmd.accept) begin
			if (!building_q) begin
				if (is_amp && !last_in_text) begin
					building_q <= 1'b1;
					pos_q      <= AW'(1);
				end
			end else if (hit || go_flush) begin
				building_q <= 1'b0;
				pos_q      <= '0;
			end else begin
				pos_q <= pos_q + AW'(1);
			end
		end
	end

	// reference parse, refreshed at each character accepted outside a sequence
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			if (!building_q) begin
				name_ok_q <= '1;
				hash_ok_q <= 1'b0;
				hex_q     <= 1'b0;
				bad_q     <= 1'b0;
				ndig_q    <= 1'b0;
				ovf_q     <= 1'b0;
				acc_q     <= '0;
			end else begin
				name_ok_q <= name_step;
				if (pos_q == AW'(1)) begin
					hash_ok_q <= is_hash;
				end else if (pos_q == AW'(2)) begin
					if (char_in == xed_pkg::CH_X) begin
						hex_q <= 1'b1;
					end else if (dec_d) begin
						acc_q  <= CW'(dval);
						ndig_q <= 1'b1;
					end else begin
						bad_q <= 1'b1;
					end
				end else if (dig_ok) begin
					acc_q  <= acc_next[CW-1:0];
					ovf_q  <= ovf_q || (acc_next > XW'(xed_pkg::CP_MAX));
					ndig_q <= 1'b1;
				end else begin
					bad_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && (building_q || is_amp)) begin
			seq_mem[pos_q] <= char_in;
		end
		if (rd_en) begin
			rd_data_s1 <= seq_mem[iss_q];
			rd_last_s1 <= iss_q == end_q;
		end
		if (cmd.accept && go_flush) begin
			end_q      <= pos_q;
			flush_te_q <= last_in_text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q       <= '0;
			iss_done_q  <= 1'b1;
			data_vld_s1 <= 1'b0;
		end else if (cmd.accept && go_flush) begin
			iss_q       <= '0;
			iss_done_q  <= 1'b0;
			data_vld_s1 <= 1'b0;
		end else if (rd_en) begin
			iss_q       <= iss_q + AW'(1);
			iss_done_q  <= iss_q == end_q;
			data_vld_s1 <= 1'b1;
		end else if (load) begin
			data_vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_now || load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_now) begin
			char_out_q <= building_q ? hit_val : char_in;
			run_last_q <= 1'b1;
			text_end_q <= last_in_text;
		end else if (load) begin
			char_out_q <= rd_data_s1;
			run_last_q <= rd_last_s1;
			text_end_q <= rd_last_s1 && flush_te_q;
		end
	end

	assign char_out  = char_out_q;
	assign run_last  = run_last_q;
	assign text_end  = text_end_q;
	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_pos_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!building_q |-> pos_q == '0)
		else $error("buffer position not cleared outside a sequence");
	a_no_accept_in_flush: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |-> !cmd.accept)
		else $error("transaction accepted during flush");
	a_stage_in_flush: assert property (@(posedge clk) disable iff (!arst_n)
		data_vld_s1 |-> cmd.flush)
		else $error("read stage holds data outside flush");
	a_done_exit: assert property (@(posedge clk) disable iff (!arst_n)
		st.flush_done |=> !cmd.flush && !building_q)
		else $error("flush did not end after its last entry");
`endif

endmodule

// ===== hw/rtl/xml_entity_decoder_top.sv =====
`timescale 1ns / 1ps
// a passed or substituted character is registered and presented in the cycle after its transaction
// verbatim flush of n buffered characters: after the closing transaction each entry passes the
// buffer read stage and then the output register; no input is taken until the flush completes
// throughput: 1 character per cycle outside flushes, the output register refilling as it drains
// flushes are read out one entry per cycle, while the output accepts, through the single buffer read port
// reset: arst_n clears the sequence position and flag, the flush pipeline and the output valid flag

module xml_entity_decoder_top #(
	parameter int MAX_SEQ = 16
) (
	input logic       clk,
	input logic       arst_n,
	xed_in_if.sink    raw,
	xed_out_if.source dec
);

	xed_pkg::dp_cmd_t    cmd;
	xed_pkg::dp_status_t st;

	xed_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (raw.valid),
		.in_ready (raw.ready),
		.st       (st),
		.cmd      (cmd)
	);

	xed_dpath #(
		.MAX_SEQ (MAX_SEQ)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.char_in      (raw.char_in),
		.last_in_text (raw.last_in_text),
		.char_out     (dec.char_out),
		.run_last     (dec.run_last),
		.text_end     (dec.text_end),
		.out_valid    (dec.valid),
		.out_ready    (dec.ready)
	);

endmodule
